/* rtl/round_robin_ready_queue_core_macros.svh */
// assertion macros for the round-robin ready queue
// used by rtl modules that carry concurrent checks; no other dependencies
`ifndef ROUND_ROBIN_READY_QUEUE_CORE_MACROS_SVH
`define ROUND_ROBIN_READY_QUEUE_CORE_MACROS_SVH

// same-cycle implication, masked during reset
`define RRQ_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rrq assertion failed");

// next-cycle implication, masked during reset
`define RRQ_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rrq assertion failed");

`endif

/* rtl/rrq_pkg.sv */
// shared types and constants for the round-robin ready queue
// no dependencies; used by the interfaces, the entry store and the top level
package rrq_pkg;

   localparam int QUEUE_DEPTH = 16;
   localparam int PID_BITS    = 16;

   localparam int ADDR_BITS        = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int COUNT_BITS       = $clog2(QUEUE_DEPTH + 1);
   localparam int PID_FIELD_BITS   = 16;
   localparam int COUNT_FIELD_BITS = 5;

   typedef logic [PID_BITS-1:0]         pid_type;
   typedef logic [ADDR_BITS-1:0]        addr_type;
   typedef logic [COUNT_BITS-1:0]       count_type;
   typedef logic [PID_FIELD_BITS-1:0]   pid_field_type;
   typedef logic [COUNT_FIELD_BITS-1:0] count_field_type;

   typedef enum logic [1:0] {
      OP_APPEND = 2'd0,
      OP_REMOVE = 2'd1,
      OP_ROTATE = 2'd2,
      OP_LOOKUP = 2'd3
   } opcode_type;

   typedef enum logic [1:0] {
      ST_OK     = 2'd0,
      ST_ABSENT = 2'd1,
      ST_FULL   = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SEARCH,
      S_SHIFT,
      S_ROT_HEAD,
      S_ROT_TAIL,
      S_HEAD_RD,
      S_LOAD,
      S_RESP
   } state_type;

   // one write and one read port of the entry store
   typedef struct packed {
      logic     wr_en;
      addr_type wr_addr;
      pid_type  wr_data;
      logic     rd_en;
      addr_type rd_addr;
   } mem_req_type;

endpackage

/* rtl/rrq_if.sv */
// valid/ready channel interfaces for requests and responses
// depends on rrq_pkg for field widths
interface rrq_req_if;
   logic                   valid;
   logic                   ready;
   logic [1:0]             req_type;
   rrq_pkg::pid_field_type pid;

   modport source (output valid, req_type, pid, input ready);
   modport sink   (input valid, req_type, pid, output ready);
endinterface

interface rrq_rsp_if;
   logic                     valid;
   logic                     ready;
   logic [1:0]               status;
   rrq_pkg::pid_field_type   head_pid;
   rrq_pkg::count_field_type count;

   modport source (output valid, status, head_pid, count, input ready);
   modport sink   (input valid, status, head_pid, count, output ready);
endinterface

/* rtl/rrq_store.sv */
// entry store of the ready queue: one write port, one registered read port
// depends on rrq_pkg
module rrq_store (
   input  logic                 clock,
   input  rrq_pkg::mem_req_type mem_req,
   output rrq_pkg::pid_type     rd_data
);

   rrq_pkg::pid_type mem [rrq_pkg::QUEUE_DEPTH];
   rrq_pkg::pid_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         mem[mem_req.wr_addr] <= mem_req.wr_data;
      end
      if (mem_req.rd_en) begin
         rd_data_ff <= mem[mem_req.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/round_robin_ready_queue_core.sv */
// round-robin ready queue: sequencer, shared id comparator and response registers
// depends on rrq_pkg, rrq_if, rrq_store and the assertion macro header
//
// usage
//   req_if carries one transaction per request: req_type (append, remove, rotate,
//   lookup) and pid. rsp_if returns exactly one transaction per request: status,
//   head_pid (0 when empty) and count, all as they stand after the request.
// timing
//   one request at a time. the ids sit in a single-port-read store, so search and
//   gap closing walk it one entry per cycle; only search uses the one comparator.
//   append, refused append, empty-queue cases: read the head, then respond.
//   lookup: search from the head to the first match, read the head, respond.
//   remove: search, shift the entries behind the match down, read the head, respond.
//   rotate, two or more ids: hold the head, shift the rest down, put it at the tail.
//   a new request is taken in the cycle its predecessor's response is taken.
// reset
//   synchronous, active high: queue empty, sequencer idle, no response pending.
//   the id store is not cleared; only the first count entries are ever used.
// back-pressure
//   a response waits in its registers while rsp_if.ready is low; no request is
//   taken until it leaves.
`include "round_robin_ready_queue_core_macros.svh"

module round_robin_ready_queue_core (
   input logic        clock,
   input logic        reset,
   rrq_req_if.sink    req_if,
   rrq_rsp_if.source  rsp_if
);

   rrq_pkg::state_type   state_ff, state_in;
   rrq_pkg::count_type   count_ff, count_in;
   rrq_pkg::opcode_type  op_ff, op_in;
   rrq_pkg::pid_type     pid_ff, pid_in;
   rrq_pkg::addr_type    idx_ff, idx_in;
   rrq_pkg::pid_type     hold_ff, hold_in;
   rrq_pkg::status_type  status_ff, status_in;
   rrq_pkg::pid_type     head_ff, head_in;

   rrq_pkg::mem_req_type mem_req;
   rrq_pkg::pid_type     rd_data;

   rrq_pkg::opcode_type  req_op;
   rrq_pkg::pid_type     req_pid;
   rrq_pkg::count_type   idx_ext;
   logic                 req_fire;
   logic                 id_match;
   logic                 take_req;

   rrq_store u_store (
      .clock   (clock),
      .mem_req (mem_req),
      .rd_data (rd_data)
   );

   assign req_op   = rrq_pkg::opcode_type'(req_if.req_type);
   assign req_pid  = rrq_pkg::pid_type'(req_if.pid);
   assign req_fire = req_if.valid & req_if.ready;
   assign idx_ext  = rrq_pkg::count_type'(idx_ff);

   // the one comparator shared by lookup and remove
   assign id_match = (rd_data == pid_ff);

   always_comb begin
      state_in  = state_ff;
      count_in  = count_ff;
      op_in     = op_ff;
      pid_in    = pid_ff;
      idx_in    = idx_ff;
      hold_in   = hold_ff;
      status_in = status_ff;
      head_in   = head_ff;
      mem_req   = '0;
      take_req  = 1'b0;

      unique case (state_ff)
         rrq_pkg::S_IDLE: begin
            take_req = 1'b1;
         end
         rrq_pkg::S_SEARCH: begin
            if (id_match) begin
               if (op_ff == rrq_pkg::OP_LOOKUP) begin
                  state_in = rrq_pkg::S_HEAD_RD;
               end else if (idx_ext + rrq_pkg::count_type'(1) < count_ff) begin
                  // close the gap starting at the match
                  mem_req.rd_en   = 1'b1;
                  mem_req.rd_addr = idx_ff + rrq_pkg::addr_type'(1);
                  state_in        = rrq_pkg::S_SHIFT;
               end else begin
                  // match is the tail entry, nothing to move
                  count_in = count_ff - rrq_pkg::count_type'(1);
                  state_in = rrq_pkg::S_HEAD_RD;
               end
            end else if (idx_ext + rrq_pkg::count_type'(1) == count_ff) begin
               status_in = rrq_pkg::ST_ABSENT;
               state_in  = rrq_pkg::S_HEAD_RD;
            end else begin
               mem_req.rd_en   = 1'b1;
               mem_req.rd_addr = idx_ff + rrq_pkg::addr_type'(1);
               idx_in          = idx_ff + rrq_pkg::addr_type'(1);
            end
         end
         rrq_pkg::S_SHIFT: begin
            // rd_data holds entry idx+1, moved down to idx
            mem_req.wr_en   = 1'b1;
            mem_req.wr_addr = idx_ff;
            mem_req.wr_data = rd_data;
            if (idx_ext + rrq_pkg::count_type'(2) < count_ff) begin
               mem_req.rd_en   = 1'b1;
               mem_req.rd_addr = idx_ff + rrq_pkg::addr_type'(2);
               idx_in          = idx_ff + rrq_pkg::addr_type'(1);
            end else if (op_ff == rrq_pkg::OP_ROTATE) begin
               state_in = rrq_pkg::S_ROT_TAIL;
            end else begin
               count_in = count_ff - rrq_pkg::count_type'(1);
               state_in = rrq_pkg::S_HEAD_RD;
            end
         end
         rrq_pkg::S_ROT_HEAD: begin
            hold_in         = rd_data;
            mem_req.rd_en   = 1'b1;
            mem_req.rd_addr = rrq_pkg::addr_type'(1);
            idx_in          = '0;
            state_in        = rrq_pkg::S_SHIFT;
         end
         rrq_pkg::S_ROT_TAIL: begin
            mem_req.wr_en   = 1'b1;
            mem_req.wr_addr = rrq_pkg::addr_type'(count_ff - rrq_pkg::count_type'(1));
            mem_req.wr_data = hold_ff;
            state_in        = rrq_pkg::S_HEAD_RD;
         end
         rrq_pkg::S_HEAD_RD: begin
            mem_req.rd_en   = 1'b1;
            mem_req.rd_addr = '0;
            state_in        = rrq_pkg::S_LOAD;
         end
         rrq_pkg::S_LOAD: begin
            head_in  = (count_ff == '0) ? '0 : rd_data;
            state_in = rrq_pkg::S_RESP;
         end
         rrq_pkg::S_RESP: begin
            if (rsp_if.ready) begin
               take_req = 1'b1;
               state_in = rrq_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = rrq_pkg::S_IDLE;
         end
      endcase

      // start of a new transaction
      if (take_req && req_if.valid) begin
         op_in     = req_op;
         pid_in    = req_pid;
         status_in = rrq_pkg::ST_OK;
         idx_in    = '0;
         state_in  = rrq_pkg::S_HEAD_RD;
         case (req_op)
            rrq_pkg::OP_APPEND: begin
               if (count_ff >= rrq_pkg::count_type'(rrq_pkg::QUEUE_DEPTH)) begin
                  status_in = rrq_pkg::ST_FULL;
               end else begin
                  mem_req.wr_en   = 1'b1;
                  mem_req.wr_addr = rrq_pkg::addr_type'(count_ff);
                  mem_req.wr_data = req_pid;
                  count_in        = count_ff + rrq_pkg::count_type'(1);
               end
            end
            rrq_pkg::OP_ROTATE: begin
               if (count_ff > rrq_pkg::count_type'(1)) begin
                  mem_req.rd_en   = 1'b1;
                  mem_req.rd_addr = '0;
                  state_in        = rrq_pkg::S_ROT_HEAD;
               end
            end
            default: begin
               // remove and lookup walk the queue from the head
               if (count_ff == '0) begin
                  status_in = rrq_pkg::ST_ABSENT;
               end else begin
                  mem_req.rd_en   = 1'b1;
                  mem_req.rd_addr = '0;
                  state_in        = rrq_pkg::S_SEARCH;
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rrq_pkg::S_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff     <= op_in;
      pid_ff    <= pid_in;
      idx_ff    <= idx_in;
      hold_ff   <= hold_in;
      status_ff <= status_in;
      head_ff   <= head_in;
   end

   assign req_if.ready    = take_req;
   assign rsp_if.valid    = (state_ff == rrq_pkg::S_RESP);
   assign rsp_if.status   = status_ff;
   assign rsp_if.head_pid = rrq_pkg::pid_field_type'(head_ff);
   assign rsp_if.count    = rrq_pkg::count_field_type'(count_ff);

   // occupancy never exceeds capacity
   `RRQ_ASSERT_IMPLIES(a_count_bound, clock, reset, 1'b1,
      count_ff <= rrq_pkg::count_type'(rrq_pkg::QUEUE_DEPTH))
   // the search pointer stays inside the occupied region
   `RRQ_ASSERT_IMPLIES(a_search_idx, clock, reset, state_ff == rrq_pkg::S_SEARCH,
      idx_ext < count_ff)
   // an accepted append into a non-full queue grows it by one
   `RRQ_ASSERT_NEXT(a_append_grow, clock, reset,
      req_fire && req_op == rrq_pkg::OP_APPEND &&
      count_ff < rrq_pkg::count_type'(rrq_pkg::QUEUE_DEPTH),
      count_ff == $past(count_ff) + rrq_pkg::count_type'(1))

endmodule
